// ===== hw/rtl/crc12_frame_checker_macros.svh =====
// ----------------------------------------------------------------------------
// crc12_frame_checker_macros.svh
// Assertion macros shared by the CRC-12 frame checker modules.
// ----------------------------------------------------------------------------
`ifndef CRC12_FRAME_CHECKER_MACROS_SVH
`define CRC12_FRAME_CHECKER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CRC12FC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define CRC12FC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/crc12fc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc12fc_pkg
// Types, constants and the byte fold function of the CRC-12 frame checker.
// ----------------------------------------------------------------------------
package crc12fc_pkg;

    localparam int CRC_W     = 12;
    localparam int BYTE_W    = 8;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    localparam logic [CRC_W-1:0] CRC_POLY_RESET = 12'h80d;

    // Number of bytes held back from the fold.
    typedef enum logic [1:0] {
        HELD_NONE = 2'd0,
        HELD_ONE  = 2'd1,
        HELD_TWO  = 2'd2
    } held_count_t;

    typedef struct packed {
        logic [CRC_W-1:0] syndrome;
        logic             frame_ok;
        logic             short_frame;
    } crc12fc_result_t;

    // Fold one byte into the remainder, MSB first, eight shift steps.
    function automatic logic [CRC_W-1:0] crc_fold_byte(
        input logic [CRC_W-1:0]  rem,
        input logic [BYTE_W-1:0] b,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] r;
        r = rem ^ {b, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if (r[CRC_W-1]) begin
                r = {r[CRC_W-2:0], 1'b0} ^ poly;
            end else begin
                r = {r[CRC_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/crc12fc_core.sv =====
// ----------------------------------------------------------------------------
// crc12fc_core
// Frame state: running remainder, two-byte hold and the end-of-frame check.
// ----------------------------------------------------------------------------
`include "crc12_frame_checker_macros.svh"

module crc12fc_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                item_valid,
    input  logic [crc12fc_pkg::BYTE_W-1:0]      item_byte,
    input  logic                                item_last,
    input  logic [crc12fc_pkg::CRC_W-1:0]       poly,
    input  logic                                res_ready,
    output logic                                item_take,
    output logic                                res_load,
    output crc12fc_pkg::crc12fc_result_t        res
);
    import crc12fc_pkg::*;

    logic [CRC_W-1:0]  remainder_reg, remainder_next;
    logic [BYTE_W-1:0] held0_reg, held0_next;
    logic [BYTE_W-1:0] held1_reg, held1_next;
    held_count_t       held_count_reg, held_count_next;

    logic [CRC_W-1:0]  rem_upd;
    logic [BYTE_W-1:0] h0_upd, h1_upd;
    held_count_t       cnt_upd;
    logic [CRC_W-1:0]  code;

    // A last word needs room in the result register; others always go.
    assign item_take = item_valid && (!item_last || res_ready);
    assign res_load  = item_take && item_last;

    always_comb begin
        rem_upd = remainder_reg;
        h0_upd  = held0_reg;
        h1_upd  = held1_reg;
        cnt_upd = held_count_reg;
        case (held_count_reg)
            HELD_NONE: begin
                h0_upd  = item_byte;
                cnt_upd = HELD_ONE;
            end
            HELD_ONE: begin
                h1_upd  = item_byte;
                cnt_upd = HELD_TWO;
            end
            HELD_TWO: begin
                rem_upd = crc_fold_byte(remainder_reg, held0_reg, poly);
                h0_upd  = held1_reg;
                h1_upd  = item_byte;
            end
            default: begin
                cnt_upd = HELD_NONE;
            end
        endcase

        code = {h0_upd[CRC_W-BYTE_W-1:0], h1_upd};
        if (cnt_upd != HELD_TWO) begin
            res.syndrome    = '0;
            res.frame_ok    = 1'b0;
            res.short_frame = 1'b1;
        end else begin
            res.syndrome    = rem_upd ^ code;
            res.frame_ok    = (rem_upd == code);
            res.short_frame = 1'b0;
        end

        remainder_next  = remainder_reg;
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        held_count_next = held_count_reg;
        if (item_take) begin
            if (item_last) begin
                // drop the frame state for the next frame
                remainder_next  = '0;
                held0_next      = '0;
                held1_next      = '0;
                held_count_next = HELD_NONE;
            end else begin
                remainder_next  = rem_upd;
                held0_next      = h0_upd;
                held1_next      = h1_upd;
                held_count_next = cnt_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remainder_reg  <= '0;
            held0_reg      <= '0;
            held1_reg      <= '0;
            held_count_reg <= HELD_NONE;
        end else begin
            remainder_reg  <= remainder_next;
            held0_reg      <= held0_next;
            held1_reg      <= held1_next;
            held_count_reg <= held_count_next;
        end
    end

    `CRC12FC_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, res_load, remainder_reg == '0 && held_count_reg == HELD_NONE, "frame state not cleared after last word")
    `CRC12FC_ASSERT(a_short_result, aclk, aresetn, !res.short_frame || (res.syndrome == '0 && !res.frame_ok), "short frame result carries syndrome or ok")
    `CRC12FC_ASSERT(a_rem_zero_early, aclk, aresetn, held_count_reg == HELD_TWO || remainder_reg == '0, "remainder moved before any byte was folded")
    `CRC12FC_ASSERT(a_ok_matches, aclk, aresetn, !res.frame_ok || res.syndrome == '0, "ok flag with nonzero syndrome")

endmodule

// ===== hw/rtl/crc12fc_out_buf.sv =====
// ----------------------------------------------------------------------------
// crc12fc_out_buf
// Result register on the master side; holds a word until it is taken.
// ----------------------------------------------------------------------------
`include "crc12_frame_checker_macros.svh"

module crc12fc_out_buf (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 res_load,
    input  crc12fc_pkg::crc12fc_result_t         res,
    output logic                                 res_ready,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [crc12fc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [crc12fc_pkg::M_TUSER_W-1:0]    m_tuser
);
    import crc12fc_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    crc12fc_result_t res_reg;

    assign res_ready  = !valid_reg || m_tready;
    assign valid_next = res_load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W-CRC_W){1'b0}}, res_reg.syndrome};
    assign m_tuser  = {res_reg.short_frame, res_reg.frame_ok};

    `CRC12FC_ASSERT(a_no_overwrite, aclk, aresetn, !res_load || !valid_reg || m_tready, "result loaded over a word not yet taken")

endmodule

// ===== hw/rtl/crc12_frame_checker.sv =====
// ----------------------------------------------------------------------------
// crc12_frame_checker
// CRC-12 check of a framed byte stream, MSB first, programmable polynomial.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on the slave side while no last byte waits for the
// result register, s_tlast marking the last byte of a frame. The last two
// bytes of a frame are the received code (big-endian, low 12 bits kept); the
// eight-step byte fold between the input register and the frame state folds
// every earlier byte into a remainder that starts at zero. For each frame one
// word goes out of the result register on the master side after its last byte
// leaves the input register: the syndrome in m_tdata and the flags in m_tuser.
// A frame of fewer than two bytes gives short_frame with syndrome 0. The
// polynomial (reset 0x80d) is written through cfg_wr_en/cfg_wr_data by the
// user, only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module crc12_frame_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [crc12fc_pkg::CRC_W-1:0]        cfg_wr_data,   // polynomial
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [crc12fc_pkg::S_TDATA_W-1:0]    s_tdata,       // [7:0] data_byte
    input  logic                                 s_tlast,       // end_of_frame
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [crc12fc_pkg::M_TDATA_W-1:0]    m_tdata,       // [11:0] syndrome
    output logic [crc12fc_pkg::M_TUSER_W-1:0]    m_tuser        // [0] frame_ok, [1] short_frame
);
    import crc12fc_pkg::*;

    logic [CRC_W-1:0]  poly_reg;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              s_accept;

    logic              item_take;
    logic              res_load;
    logic              res_ready;
    crc12fc_result_t   res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= CRC_POLY_RESET;
        end else if (cfg_wr_en) begin
            poly_reg <= cfg_wr_data;
        end
    end

    assign s_tready      = !in_valid_reg || item_take;
    assign s_accept      = s_tvalid && s_tready;
    assign in_valid_next = s_accept || (in_valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    crc12fc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item_byte  (in_byte_reg),
        .item_last  (in_last_reg),
        .poly       (poly_reg),
        .res_ready  (res_ready),
        .item_take  (item_take),
        .res_load   (res_load),
        .res        (res)
    );

    crc12fc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_load  (res_load),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== tb/crc12_syndrome_monitor.sv =====
// ----------------------------------------------------------------------------
// crc12_syndrome_monitor
// Watches both streams of the CRC-12 frame checker and checks every result.
// ----------------------------------------------------------------------------
// Tracks the polynomial from the configuration port, predicts the syndrome
// and flags of each frame from the accepted bytes, and compares each result
// word on the master side with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
package crc12fc_tb_pkg;

    typedef logic [7:0] byte_q_t [$];

    // Fold one byte into a 12-bit remainder, MSB first.
    function automatic logic [11:0] crc12_fold(
        input logic [11:0] acc,
        input logic [7:0]  b,
        input logic [11:0] poly
    );
        logic [11:0] r;
        logic        msb;
        r = acc ^ {b, 4'h0};
        repeat (8) begin
            msb = r[11];
            r   = r << 1;
            if (msb) begin
                r = r ^ poly;
            end
        end
        return r;
    endfunction

endpackage

module crc12_syndrome_monitor
    import crc12fc_pkg::*;
    import crc12fc_tb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CRC_W-1:0]     cfg_wr_data,   // polynomial
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // [7:0] data_byte
    input  logic                 s_tlast,       // end_of_frame
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,       // [11:0] syndrome
    input  logic [M_TUSER_W-1:0] m_tuser,       // [0] frame_ok, [1] short_frame
    output int                   mismatches,
    output int                   pending,
    output int                   compared
);

    logic [CRC_W-1:0]  poly_reg;
    logic [CRC_W-1:0]  crc_acc;
    logic [7:0]        hold_q [2];
    held_count_t       hold_cnt;
    crc12fc_result_t   syndromes_due [$];
    int                err_count;
    int                cmp_count;
    int                pend_count;

    assign mismatches = err_count;
    assign pending    = pend_count;
    assign compared   = cmp_count;

    task automatic note_mismatch(input string what, input int got, input int want);
        if (err_count < 100) begin
            $display("mismatch in %s: got 0x%0h, want 0x%0h", what, got, want);
        end
        err_count++;
    endtask

    task automatic clear_frame();
        crc_acc   = '0;
        hold_q[0] = '0;
        hold_q[1] = '0;
        hold_cnt  = HELD_NONE;
    endtask

    // Take one accepted byte; on the frame end queue the expected result.
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        crc12fc_result_t res;
        logic [11:0]     code;
        if (hold_cnt == HELD_TWO) begin
            crc_acc   = crc12_fold(crc_acc, hold_q[0], poly_reg);
            hold_q[0] = hold_q[1];
            hold_q[1] = b;
        end else if (hold_cnt == HELD_ONE) begin
            hold_q[1] = b;
            hold_cnt  = HELD_TWO;
        end else begin
            hold_q[0] = b;
            hold_cnt  = HELD_ONE;
        end
        if (last) begin
            if (hold_cnt != HELD_TWO) begin
                res.syndrome    = '0;
                res.frame_ok    = 1'b0;
                res.short_frame = 1'b1;
            end else begin
                code            = {hold_q[0][3:0], hold_q[1]};
                res.syndrome    = crc_acc ^ code;
                res.frame_ok    = (res.syndrome == '0);
                res.short_frame = 1'b0;
            end
            syndromes_due.push_back(res);
            clear_frame();
        end
    endtask

    task automatic compare_word();
        crc12fc_result_t want;
        if (syndromes_due.size() == 0) begin
            note_mismatch("result word with no frame pending", m_tdata, 0);
        end else begin
            want = syndromes_due.pop_front();
            cmp_count++;
            if (m_tdata[CRC_W-1:0] !== want.syndrome) begin
                note_mismatch("syndrome", m_tdata[CRC_W-1:0], want.syndrome);
            end
            if (m_tdata[M_TDATA_W-1:CRC_W] !== '0) begin
                note_mismatch("tdata padding", m_tdata[M_TDATA_W-1:CRC_W], 0);
            end
            if (m_tuser[0] !== want.frame_ok) begin
                note_mismatch("frame_ok", m_tuser[0], want.frame_ok);
            end
            if (m_tuser[1] !== want.short_frame) begin
                note_mismatch("short_frame", m_tuser[1], want.short_frame);
            end
        end
    endtask

    initial begin
        err_count  = 0;
        cmp_count  = 0;
        pend_count = 0;
        poly_reg   = CRC_POLY_RESET;
        clear_frame();
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg = CRC_POLY_RESET;
            clear_frame();
            syndromes_due.delete();
        end else begin
            if (cfg_wr_en) begin
                poly_reg = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                absorb_byte(s_tdata[7:0], s_tlast);
            end
            if (m_tvalid && m_tready) begin
                compare_word();
            end
        end
        pend_count = syndromes_due.size();
    end

endmodule

// ===== tb/tb_crc12_frame_checker.sv =====
// ----------------------------------------------------------------------------
// tb_crc12_frame_checker
// Stimulus and verdict for the CRC-12 frame checker.
// ----------------------------------------------------------------------------
// Sends directed frames (short frames, bare codes, a polynomial change in the
// middle of a frame), then random frames, mostly with a correct code, under
// several polynomials and idle patterns on both sides, and one long receiver
// hold-off. The monitor beside the block predicts and checks every result.
// ----------------------------------------------------------------------------
module tb_crc12_frame_checker;
    import crc12fc_pkg::*;
    import crc12fc_tb_pkg::*;

    localparam int LIMIT  = 300000;
    localparam int SETTLE = 8;
    localparam int HOLD   = 300;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CRC_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int          mismatches;
    int          pending;
    int          compared;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          frames_sent;
    int          bytes_sent;
    bit          hold_req;
    logic [11:0] cur_poly;

    crc12_frame_checker uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    crc12_syndrome_monitor mon (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .pending     (pending),
        .compared    (compared)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    // Receiver: random backpressure, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD) @(negedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic logic [11:0] frame_code(input byte_q_t body, input logic [11:0] poly);
        logic [11:0] acc;
        acc = '0;
        foreach (body[i]) begin
            acc = crc12_fold(acc, body[i], poly);
        end
        return acc;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 1;
        if (r < 20) return 2;
        if (r < 92) return $urandom_range(3, 10);
        return $urandom_range(11, 40);
    endfunction

    // Offer one word and hold it until taken; called and returns at a falling edge.
    task automatic push_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_seq(input byte_q_t seq, input bit ends);
        foreach (seq[i]) begin
            push_byte(seq[i], ends && (i == seq.size() - 1));
        end
        if (ends) begin
            frames_sent++;
        end
    endtask

    task automatic send_frame(input int len, input bit good);
        byte_q_t     seq;
        logic [11:0] code;
        int          pos;
        seq = {};
        for (int k = 0; k < len - 2; k++) begin
            seq.push_back(8'($urandom));
        end
        if (len < 2) begin
            seq.push_back(8'($urandom));
        end else if (good || $urandom_range(0, 1) == 1) begin
            code = frame_code(seq, cur_poly);
            // upper nibble of the code byte is masked off by the block
            seq.push_back({4'($urandom), code[11:8]});
            seq.push_back(code[7:0]);
            if (!good) begin
                pos = $urandom_range(0, len - 1);
                seq[pos] = seq[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
        end else begin
            seq.push_back(8'($urandom));
            seq.push_back(8'($urandom));
        end
        send_seq(seq, 1'b1);
    endtask

    // Drain all results, let the pipeline empty, then load a new polynomial.
    task automatic settle_and_write(input logic [11:0] p);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        cfg_wr_data <= p;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_poly = p;
        @(negedge aclk);
    endtask

    task automatic random_phase(input int nbytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < nbytes) begin
            send_frame(pick_len(), $urandom_range(0, 99) < 65);
        end
    endtask

    initial begin
        logic [11:0] code;
        byte_q_t     body;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        hold_req      = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 83;
        frames_sent   = 0;
        bytes_sent    = 0;
        cur_poly      = CRC_POLY_RESET;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed frames under the reset polynomial
        send_seq('{8'h00}, 1'b1);
        send_seq('{8'hff}, 1'b1);
        send_seq('{8'hff, 8'hff}, 1'b1);
        send_seq('{8'h00, 8'h00}, 1'b1);
        send_seq('{8'ha5, 8'h5a}, 1'b1);
        body = '{8'h80};
        code = frame_code(body, cur_poly);
        send_seq('{8'h80, {4'hf, code[11:8]}, code[7:0]}, 1'b1);
        body = '{8'hff, 8'h01, 8'h7f};
        code = frame_code(body, cur_poly);
        send_seq('{8'hff, 8'h01, 8'h7f, {4'h0, code[11:8]}, code[7:0]}, 1'b1);
        // polynomial change in the middle of a frame
        send_seq('{8'h11, 8'h22, 8'h33}, 1'b0);
        settle_and_write(12'hfff);
        send_seq('{8'h44, 8'h55}, 1'b1);

        settle_and_write(12'h80f);
        random_phase(250);

        send_idle_pct = 83;
        recv_idle_pct = 18;
        settle_and_write(12'h000);
        random_phase(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle_and_write(12'($urandom));
        random_phase(250);

        // long receiver hold-off while short frames keep coming
        settle_and_write(CRC_POLY_RESET);
        hold_req = 1'b1;
        repeat (60) begin
            send_frame($urandom_range(1, 3), $urandom_range(0, 1) == 1);
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d frames, %0d bytes, five polynomials incl. 0x000 and 0xfff,",
                 frames_sent, bytes_sent);
        $display("idle and stall mixes on both sides and a long hold-off; %0d results compared",
                 compared);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
